>>> design/dgr_pkg.sv
// shared types, constants and defaults for the droplet grid router step core
package dgr_pkg;

    localparam int GRID_ROWS_DEF     = 720;
    localparam int GRID_COLS_DEF     = 1280;
    localparam int MAX_DROP_SIZE_DEF = 64;
    localparam int GUARD_CELLS_DEF   = 2;

    localparam int COORD_W = 15;
    typedef logic signed [COORD_W-1:0] coord_t;

    // actions
    localparam logic [1:0] ACT_PLACE = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // phases
    localparam logic [2:0] PH_ROW_CH  = 3'd0;
    localparam logic [2:0] PH_COL_CH  = 3'd1;
    localparam logic [2:0] PH_ROW_TGT = 3'd2;
    localparam logic [2:0] PH_ARRIVED = 3'd4;

    // route classes
    localparam logic [1:0] CLS_UPPER_RIGHT = 2'd0;
    localparam logic [1:0] CLS_UPPER_LEFT  = 2'd1;
    localparam logic [1:0] CLS_LOWER_LEFT  = 2'd2;
    localparam logic [1:0] CLS_LOWER_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_UP_MARGIN       = 3'd0;
    localparam logic [2:0] CFG_DOWN_MARGIN     = 3'd1;
    localparam logic [2:0] CFG_UPPER_RIGHT_ROW = 3'd2;
    localparam logic [2:0] CFG_UPPER_LEFT_ROW  = 3'd3;
    localparam logic [2:0] CFG_LOWER_LEFT_ROW  = 3'd4;
    localparam logic [2:0] CFG_LOWER_RIGHT_ROW = 3'd5;

    typedef struct packed {
        logic load;
        logic plan;
        logic ginit;
        logic winit;
        logic zinit;
        logic rd;
        logic wr;
        logic zero;
        logic next;
        logic block;
    } dgr_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic need_guard;
        logic need_write;
        logic empty;
        logic last;
        logic hit;
    } dgr_stat_t;

    typedef struct packed {
        logic signed [11:0] new_row;
        logic signed [11:0] new_col;
        logic [2:0]         new_phase;
        logic               moved;
        logic               blocked;
        logic               still_active;
        logic [1:0]         route_class;
    } dgr_res_t;

endpackage

>>> design/dgr_ctrl.sv
// sequencing state machine for the droplet grid router step core
module dgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    input  dgr_pkg::dgr_stat_t st,
    output logic              in_stall,
    output logic              done,
    output dgr_pkg::dgr_cmd_t cmd
);
    import dgr_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PLAN = 4'd2;
    localparam logic [3:0] S_DISP = 4'd3;
    localparam logic [3:0] S_GRD  = 4'd4;
    localparam logic [3:0] S_GCHK = 4'd5;
    localparam logic [3:0] S_WRD  = 4'd6;
    localparam logic [3:0] S_WWR  = 4'd7;
    localparam logic [3:0] S_ZERO = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.wr   = 1'b1;
                cmd.zero = 1'b1;
                cmd.next = 1'b1;
                if (st.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                priority if (st.is_clear)
                begin
                    cmd.zinit  = 1'b1;
                    state_next = S_ZERO;
                end
                else if (st.need_guard)
                begin
                    cmd.ginit  = 1'b1;
                    state_next = S_GRD;
                end
                else if (st.need_write)
                begin
                    cmd.winit  = 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_GRD:
            begin
                if (st.empty)
                begin
                    cmd.winit  = 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_GCHK;
                end
            end
            S_GCHK:
            begin
                priority if (st.hit)
                begin
                    cmd.block  = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.last)
                begin
                    cmd.winit  = 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = S_GRD;
                end
            end
            S_WRD:
            begin
                if (st.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_WWR;
                end
            end
            S_WWR:
            begin
                cmd.wr = 1'b1;
                if (st.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = S_WRD;
                end
            end
            S_ZERO:
            begin
                cmd.wr   = 1'b1;
                cmd.zero = 1'b1;
                cmd.next = 1'b1;
                if (st.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_block_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.block |-> $past(cmd.rd))
        else $error("guard block without a row read");

    a_rmw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WWR) |-> $past(cmd.rd))
        else $error("row write without preceding read");

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_free && in_stall))
        else $error("result finished while output slot busy");

    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd && cmd.wr))
        else $error("memory read and write in same cycle");

endmodule

>>> design/dgr_dp.sv
// datapath: item registers, planning, row sweeper and occupancy memory
module dgr_dp #(
    parameter int GRID_ROWS     = dgr_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS     = dgr_pkg::GRID_COLS_DEF,
    parameter int MAX_DROP_SIZE = dgr_pkg::MAX_DROP_SIZE_DEF,
    parameter int GUARD_CELLS   = dgr_pkg::GUARD_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dgr_pkg::dgr_cmd_t  cmd,
    output dgr_pkg::dgr_stat_t st,
    output dgr_pkg::dgr_res_t  res,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [10:0]        cfg_wdata,
    input  logic [1:0]         action,
    input  logic signed [11:0] cur_row,
    input  logic signed [11:0] cur_col,
    input  logic [6:0]         drop_width,
    input  logic [6:0]         drop_height,
    input  logic [1:0]         route_kind,
    input  logic [2:0]         phase,
    input  logic signed [11:0] target_row,
    input  logic signed [11:0] target_col,
    input  logic [6:0]         target_width
);
    import dgr_pkg::*;

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int HALF  = GRID_ROWS / 2;
    localparam logic [ROW_W:0] ROWS_END = (ROW_W+1)'(GRID_ROWS);

    function automatic logic [6:0] sat_size(input logic [6:0] v);
        return (int'(v) > MAX_DROP_SIZE) ? 7'(MAX_DROP_SIZE) : v;
    endfunction

    function automatic logic [GRID_COLS-1:0] col_mask(input coord_t lo, input coord_t hi);
        logic [GRID_COLS-1:0] m;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            m[j] = (coord_t'(j) >= lo) && (coord_t'(j) < hi);
        end
        return m;
    endfunction

    function automatic logic [ROW_W:0] clip_row(input coord_t v);
        logic [ROW_W:0] o;
        if (v < 0)
        begin
            o = '0;
        end
        else if (v > coord_t'(GRID_ROWS))
        begin
            o = ROWS_END;
        end
        else
        begin
            o = v[ROW_W:0];
        end
        return o;
    endfunction

    // configuration
    logic [10:0] up_margin_reg, down_margin_reg;
    logic [9:0]  ur_row_reg, ul_row_reg, ll_row_reg, lr_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_margin_reg   <= '0;
            down_margin_reg <= '0;
            ur_row_reg      <= '0;
            ul_row_reg      <= '0;
            ll_row_reg      <= '0;
            lr_row_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_UP_MARGIN:       up_margin_reg   <= cfg_wdata;
                CFG_DOWN_MARGIN:     down_margin_reg <= cfg_wdata;
                CFG_UPPER_RIGHT_ROW: ur_row_reg      <= cfg_wdata[9:0];
                CFG_UPPER_LEFT_ROW:  ul_row_reg      <= cfg_wdata[9:0];
                CFG_LOWER_LEFT_ROW:  ll_row_reg      <= cfg_wdata[9:0];
                CFG_LOWER_RIGHT_ROW: lr_row_reg      <= cfg_wdata[9:0];
                default:             ;
            endcase
        end
    end

    // item registers
    logic [1:0]         act_reg, kind_reg;
    logic [2:0]         ph_reg;
    logic signed [11:0] r_reg, c_reg, tr_reg, tc_reg;
    logic [6:0]         w_reg, h_reg, tw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            r_reg    <= cur_row;
            c_reg    <= cur_col;
            w_reg    <= sat_size(drop_width);
            h_reg    <= sat_size(drop_height);
            kind_reg <= route_kind;
            ph_reg   <= phase;
            tr_reg   <= target_row;
            tc_reg   <= target_col;
            tw_reg   <= sat_size(target_width);
        end
    end

    // planning
    coord_t rr, cc, ww, hh, trr, tcc, tww, left_lim, right_lim, lo_edge;
    coord_t dr, dc, nr2, nc2, nrow, ncol;
    logic   go, in_range, is_place, is_step, is_clear, active, do_go, arrive;
    logic [2:0] nph;
    logic [1:0] cls;

    always_comb
    begin
        rr        = coord_t'(r_reg);
        cc        = coord_t'(c_reg);
        ww        = coord_t'(w_reg);
        hh        = coord_t'(h_reg);
        trr       = coord_t'(tr_reg);
        tcc       = coord_t'(tc_reg);
        tww       = coord_t'(tw_reg);
        left_lim  = tcc - coord_t'(down_margin_reg);
        right_lim = tcc + tww + coord_t'(up_margin_reg);
        lo_edge   = tcc + tww - ww;
        is_place  = (act_reg == ACT_PLACE);
        is_step   = (act_reg == ACT_STEP);
        is_clear  = (act_reg == ACT_CLEAR);
        active    = is_step && (ph_reg < PH_ARRIVED);
        go        = 1'b0;
        dr        = '0;
        dc        = '0;
        unique case (ph_reg[1:0])
            PH_ROW_CH[1:0]:
            begin
                unique case (kind_reg)
                    CLS_UPPER_RIGHT:
                    begin
                        go = rr < coord_t'(ur_row_reg);
                        dr = coord_t'(1);
                    end
                    CLS_UPPER_LEFT:
                    begin
                        go = rr < coord_t'(ul_row_reg);
                        dr = coord_t'(1);
                    end
                    CLS_LOWER_LEFT:
                    begin
                        go = rr > coord_t'(ll_row_reg);
                        dr = -coord_t'(1);
                    end
                    default:
                    begin
                        go = rr > coord_t'(lr_row_reg);
                        dr = -coord_t'(1);
                    end
                endcase
            end
            PH_COL_CH[1:0]:
            begin
                unique case (kind_reg)
                    CLS_UPPER_RIGHT: begin go = cc < left_lim;  dc = coord_t'(1); end
                    CLS_UPPER_LEFT:  begin go = cc > left_lim;  dc = -coord_t'(1); end
                    CLS_LOWER_LEFT:  begin go = cc < right_lim; dc = coord_t'(1); end
                    default:         begin go = cc > right_lim; dc = -coord_t'(1); end
                endcase
            end
            PH_ROW_TGT[1:0]:
            begin
                if (kind_reg[1] == 1'b0)
                begin
                    go = rr < trr;
                    dr = coord_t'(1);
                end
                else
                begin
                    go = rr > trr;
                    dr = -coord_t'(1);
                end
            end
            default:
            begin
                if (kind_reg[1] == 1'b0)
                begin
                    go = cc < tcc;
                    dc = coord_t'(1);
                end
                else
                begin
                    go = cc > lo_edge;
                    dc = -coord_t'(1);
                end
            end
        endcase
        nr2      = rr + dr;
        nc2      = cc + dc;
        in_range = (nr2 >= -coord_t'(2048)) && (nr2 <= coord_t'(2047))
                && (nc2 >= -coord_t'(2048)) && (nc2 <= coord_t'(2047));
        do_go    = active && go && in_range;
        arrive   = active && !do_go && (ph_reg == 3'd3);
        nrow     = do_go ? nr2 : rr;
        ncol     = do_go ? nc2 : cc;
        if (active)
        begin
            nph = do_go ? ph_reg : ph_reg + 3'd1;
        end
        else if (is_step)
        begin
            nph = PH_ARRIVED;
        end
        else
        begin
            nph = '0;
        end
        if (is_place)
        begin
            if (rr < coord_t'(HALF))
            begin
                cls = (cc < left_lim) ? CLS_UPPER_RIGHT : CLS_UPPER_LEFT;
            end
            else
            begin
                cls = (cc < right_lim) ? CLS_LOWER_LEFT : CLS_LOWER_RIGHT;
            end
        end
        else if (is_step)
        begin
            cls = kind_reg;
        end
        else
        begin
            cls = '0;
        end
    end

    logic [GRID_COLS-1:0] old_cols_reg, new_cols_reg, grd_cols_reg;
    coord_t               nrow_reg, ncol_reg;
    logic                 set_en_reg, clr_en_reg, guard_reg, write_reg, clear_reg, active_reg;
    logic [2:0]           nph_reg;
    logic [1:0]           cls_reg;
    logic [ROW_W:0]       g_lo_reg, g_hi_reg, w_lo_reg, w_hi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            old_cols_reg <= col_mask(cc, cc + ww);
            new_cols_reg <= col_mask(ncol, ncol + ww);
            grd_cols_reg <= col_mask(nc2 - coord_t'(GUARD_CELLS),
                                     nc2 + ww + coord_t'(GUARD_CELLS));
            nrow_reg     <= nrow;
            ncol_reg     <= ncol;
            set_en_reg   <= is_place || do_go;
            clr_en_reg   <= do_go || arrive;
            guard_reg    <= do_go;
            write_reg    <= is_place || arrive;
            clear_reg    <= is_clear;
            active_reg   <= active;
            nph_reg      <= nph;
            cls_reg      <= cls;
            g_lo_reg     <= clip_row(nr2 - coord_t'(GUARD_CELLS));
            g_hi_reg     <= clip_row(nr2 + hh + coord_t'(GUARD_CELLS));
            w_lo_reg     <= clip_row((rr < nrow) ? rr : nrow);
            w_hi_reg     <= clip_row(((rr > nrow) ? rr : nrow) + hh);
        end
    end

    // row sweeper
    logic [ROW_W:0] row_reg, end_reg;
    logic           blocked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            end_reg     <= ROWS_END;
            blocked_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd.ginit)
            begin
                row_reg <= g_lo_reg;
                end_reg <= g_hi_reg;
            end
            else if (cmd.winit)
            begin
                row_reg <= w_lo_reg;
                end_reg <= w_hi_reg;
            end
            else if (cmd.zinit)
            begin
                row_reg <= '0;
                end_reg <= ROWS_END;
            end
            else if (cmd.next)
            begin
                row_reg <= row_reg + 1'b1;
            end
            if (cmd.load)
            begin
                blocked_reg <= 1'b0;
            end
            else if (cmd.block)
            begin
                blocked_reg <= 1'b1;
            end
        end
    end

    // occupancy memory, one grid row per word
    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_COLS-1:0] rd_data_reg, wr_data, clr_m, set_m, grd_m;
    coord_t               rowc;
    logic                 in_old, in_new;

    always_comb
    begin
        rowc   = coord_t'(row_reg);
        in_old = (rowc >= rr) && (rowc < rr + hh);
        in_new = (rowc >= nrow_reg) && (rowc < nrow_reg + hh);
        clr_m  = (clr_en_reg && in_old) ? old_cols_reg : '0;
        set_m  = (set_en_reg && in_new) ? new_cols_reg : '0;
        grd_m  = grd_cols_reg & ~(in_old ? old_cols_reg : '0);
        wr_data = cmd.zero ? '0 : ((rd_data_reg & ~clr_m) | set_m);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[row_reg[ROW_W-1:0]];
        end
        if (cmd.wr)
        begin
            mem[row_reg[ROW_W-1:0]] <= wr_data;
        end
    end

    always_comb
    begin
        st.is_clear   = clear_reg;
        st.need_guard = guard_reg;
        st.need_write = write_reg;
        st.empty      = (row_reg >= end_reg);
        st.last       = ((row_reg + 1'b1) == end_reg);
        st.hit        = |(rd_data_reg & grd_m);
        res.moved        = guard_reg && !blocked_reg;
        res.blocked      = blocked_reg;
        res.new_row      = res.moved ? nrow_reg[11:0] : r_reg;
        res.new_col      = res.moved ? ncol_reg[11:0] : c_reg;
        res.new_phase    = nph_reg;
        res.still_active = active_reg;
        res.route_class  = cls_reg;
    end

endmodule

>>> design/droplet_grid_router_step_core.sv
// top level of the droplet grid router step core
// the occupancy grid is held as one memory word per grid row, every cell a bit, and all
// work on it goes a row at a time through a single port. after reset the block sweeps
// the whole memory to zero and holds in_stall high until that ends; configuration writes
// are taken at any time. a step that tries to move reads the guard window (up to drop
// height plus twice GUARD_CELLS rows) and, when free, rewrites the union of the old and
// new rectangle rows; a place or an arrival rewrites only the droplet rows; a clear
// writes every row once. only one item is in work at a time; a finished result sits in
// the output register while the next item is already taken and worked on
module droplet_grid_router_step_core #(
    parameter int GRID_ROWS     = dgr_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS     = dgr_pkg::GRID_COLS_DEF,
    parameter int MAX_DROP_SIZE = dgr_pkg::MAX_DROP_SIZE_DEF,
    parameter int GUARD_CELLS   = dgr_pkg::GUARD_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [10:0]        cfg_wdata,
    // input item
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [11:0] cur_row,
    input  logic signed [11:0] cur_col,
    input  logic [6:0]         drop_width,
    input  logic [6:0]         drop_height,
    input  logic [1:0]         route_kind,
    input  logic [2:0]         phase,
    input  logic signed [11:0] target_row,
    input  logic signed [11:0] target_col,
    input  logic [6:0]         target_width,
    // result item
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] new_row,
    output logic signed [11:0] new_col,
    output logic [2:0]         new_phase,
    output logic               moved,
    output logic               blocked,
    output logic               still_active,
    output logic [1:0]         route_class
);
    import dgr_pkg::*;

    dgr_cmd_t  cmd;
    dgr_stat_t st;
    dgr_res_t  res;
    dgr_res_t  out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      done, out_free;

    // the output slot may be refilled in the cycle its item is taken
    assign out_free = !out_valid_reg || !out_stall;

    dgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .st       (st),
        .in_stall (in_stall),
        .done     (done),
        .cmd      (cmd)
    );

    dgr_dp #(
        .GRID_ROWS     (GRID_ROWS),
        .GRID_COLS     (GRID_COLS),
        .MAX_DROP_SIZE (MAX_DROP_SIZE),
        .GUARD_CELLS   (GUARD_CELLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .res          (res),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .cur_row      (cur_row),
        .cur_col      (cur_col),
        .drop_width   (drop_width),
        .drop_height  (drop_height),
        .route_kind   (route_kind),
        .phase        (phase),
        .target_row   (target_row),
        .target_col   (target_col),
        .target_width (target_width)
    );

    // output valid: set by a finished item, dropped once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_row      = out_reg.new_row;
    assign new_col      = out_reg.new_col;
    assign new_phase    = out_reg.new_phase;
    assign moved        = out_reg.moved;
    assign blocked      = out_reg.blocked;
    assign still_active = out_reg.still_active;
    assign route_class  = out_reg.route_class;

endmodule

>>> test/droplet_grid_router_step_core_tb.sv
// testbench for droplet_grid_router_step_core: directed table, random routes, predictor check
module droplet_grid_router_step_core_tb;
    import dgr_pkg::*;

    // action code with no function in the block
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int ROWS = GRID_ROWS_DEF;
    localparam int COLS = GRID_COLS_DEF;
    localparam int MAXSZ = MAX_DROP_SIZE_DEF;
    localparam int GUARD = GUARD_CELLS_DEF;
    // longest silence on both channels; a clear plus clearing after reset stay far below
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_GOAL = 1500;

    typedef struct {
        logic [1:0]         act;
        logic signed [11:0] row;
        logic signed [11:0] col;
        logic [6:0]         w;
        logic [6:0]         h;
        logic [1:0]         kind;
        logic [2:0]         ph;
        logic signed [11:0] trow;
        logic signed [11:0] tcol;
        logic [6:0]         tw;
    } item_t;

    typedef struct {
        item_t    it;
        bit       typed;
        dgr_res_t res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [10:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [11:0] cur_row;
    logic signed [11:0] cur_col;
    logic [6:0]         drop_width;
    logic [6:0]         drop_height;
    logic [1:0]         route_kind;
    logic [2:0]         phase;
    logic signed [11:0] target_row;
    logic signed [11:0] target_col;
    logic [6:0]         target_width;
    logic               out_valid;
    logic               out_stall;
    logic signed [11:0] new_row;
    logic signed [11:0] new_col;
    logic [2:0]         new_phase;
    logic               moved;
    logic               blocked;
    logic               still_active;
    logic [1:0]         route_class;

    droplet_grid_router_step_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .cur_row      (cur_row),
        .cur_col      (cur_col),
        .drop_width   (drop_width),
        .drop_height  (drop_height),
        .route_kind   (route_kind),
        .phase        (phase),
        .target_row   (target_row),
        .target_col   (target_col),
        .target_width (target_width),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_row      (new_row),
        .new_col      (new_col),
        .new_phase    (new_phase),
        .moved        (moved),
        .blocked      (blocked),
        .still_active (still_active),
        .route_class  (route_class)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // mirror of the occupancy grid and the six registers
    bit       occ [0:ROWS-1][0:COLS-1];
    int       up_mrg;
    int       down_mrg;
    int       chan_row [4];   // indexed by route class

    dgr_res_t expected_q [$];
    int       n_fail;
    int       n_items;
    int       idle_cycles;
    int       rx_hold;
    bit       calm;           // phase with no idling on either side

    function automatic int sat_size(logic [6:0] v);
        return (v > MAXSZ) ? MAXSZ : int'(v);
    endfunction

    function automatic void paint(int r, int c, int h, int w, bit v);
        for (int i = r; i < r + h; i++)
            for (int j = c; j < c + w; j++)
                if (i >= 0 && i < ROWS && j >= 0 && j < COLS)
                    occ[i][j] = v;
    endfunction

    // guard window around the new spot, ignoring the droplet's own old cells
    function automatic bit guard_clear(int orow, int ocol, int nrow, int ncol, int h, int w);
        for (int i = nrow - GUARD; i < nrow + h + GUARD; i++)
            for (int j = ncol - GUARD; j < ncol + w + GUARD; j++)
            begin
                if (i < 0 || i >= ROWS || j < 0 || j >= COLS)
                    continue;
                if (i >= orow && i < orow + h && j >= ocol && j < ocol + w)
                    continue;
                if (occ[i][j])
                    return 1'b0;
            end
        return 1'b1;
    endfunction

    // works out the result of one item and updates the mirrored grid
    function automatic dgr_res_t route_item(item_t it);
        int       r, c, w, h, tr, tc, tw, nr, nc, dr, dc, r2, c2;
        bit       go;
        logic [2:0] nph;
        dgr_res_t res;
        r = it.row;
        c = it.col;
        w = sat_size(it.w);
        h = sat_size(it.h);
        tr = it.trow;
        tc = it.tcol;
        tw = sat_size(it.tw);
        nr = r;
        nc = c;
        res = '0;
        case (it.act)
            ACT_PLACE:
            begin
                if (r < ROWS / 2)
                    res.route_class = (c < tc - down_mrg) ? CLS_UPPER_RIGHT : CLS_UPPER_LEFT;
                else
                    res.route_class = (c < tc + tw + up_mrg) ? CLS_LOWER_LEFT : CLS_LOWER_RIGHT;
                paint(r, c, h, w, 1'b1);
            end
            ACT_STEP:
            begin
                res.route_class = it.kind;
                if (it.ph >= PH_ARRIVED)
                    res.new_phase = PH_ARRIVED;
                else
                begin
                    res.still_active = 1'b1;
                    dr = 0;
                    dc = 0;
                    case (it.ph)
                        PH_ROW_CH:
                            if (it.kind == CLS_UPPER_RIGHT || it.kind == CLS_UPPER_LEFT)
                            begin
                                go = r < chan_row[it.kind];
                                dr = 1;
                            end
                            else
                            begin
                                go = r > chan_row[it.kind];
                                dr = -1;
                            end
                        PH_COL_CH:
                            case (it.kind)
                                CLS_UPPER_RIGHT: begin go = c < tc - down_mrg; dc = 1; end
                                CLS_UPPER_LEFT:  begin go = c > tc - down_mrg; dc = -1; end
                                CLS_LOWER_LEFT:  begin go = c < tc + tw + up_mrg; dc = 1; end
                                default:         begin go = c > tc + tw + up_mrg; dc = -1; end
                            endcase
                        PH_ROW_TGT:
                            if (it.kind == CLS_UPPER_RIGHT || it.kind == CLS_UPPER_LEFT)
                            begin
                                go = r < tr;
                                dr = 1;
                            end
                            else
                            begin
                                go = r > tr;
                                dr = -1;
                            end
                        default:
                            if (it.kind == CLS_UPPER_RIGHT || it.kind == CLS_UPPER_LEFT)
                            begin
                                go = c < tc;
                                dc = 1;
                            end
                            else
                            begin
                                go = c > tc + tw - w;
                                dc = -1;
                            end
                    endcase
                    nph = it.ph;
                    if (go)
                    begin
                        r2 = r + dr;
                        c2 = c + dc;
                        // stepping off the coordinate range counts as reaching the goal
                        if (r2 < -2048 || r2 > 2047 || c2 < -2048 || c2 > 2047)
                            go = 1'b0;
                        else if (guard_clear(r, c, r2, c2, h, w))
                        begin
                            paint(r, c, h, w, 1'b0);
                            paint(r2, c2, h, w, 1'b1);
                            nr = r2;
                            nc = c2;
                            res.moved = 1'b1;
                        end
                        else
                            res.blocked = 1'b1;
                    end
                    if (!go)
                    begin
                        nph = it.ph + 3'd1;
                        if (nph == PH_ARRIVED)
                            paint(r, c, h, w, 1'b0);
                    end
                    res.new_phase = nph;
                end
            end
            ACT_CLEAR:
                foreach (occ[i, j])
                    occ[i][j] = 1'b0;
            default:
            begin
            end
        endcase
        res.new_row = nr[11:0];
        res.new_col = nc[11:0];
        return res;
    endfunction

    function automatic item_t mk(logic [1:0] a, int r, int c, int w, int h, int k, int p,
                                 int tr, int tc, int tw);
        item_t it;
        it.act = a;
        it.row = r[11:0];
        it.col = c[11:0];
        it.w = w[6:0];
        it.h = h[6:0];
        it.kind = k[1:0];
        it.ph = p[2:0];
        it.trow = tr[11:0];
        it.tcol = tc[11:0];
        it.tw = tw[6:0];
        return it;
    endfunction

    function automatic dgr_res_t mk_res(int r, int c, int p, bit mv, bit bl, bit ac, int cls);
        dgr_res_t res;
        res.new_row = r[11:0];
        res.new_col = c[11:0];
        res.new_phase = p[2:0];
        res.moved = mv;
        res.blocked = bl;
        res.still_active = ac;
        res.route_class = cls[1:0];
        return res;
    endfunction

    // hands one item over and returns what the predictor made of it
    task automatic send_item(input item_t it, input bit typed, input dgr_res_t typed_res,
                             output dgr_res_t pred);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= it.act;
        cur_row      <= it.row;
        cur_col      <= it.col;
        drop_width   <= it.w;
        drop_height  <= it.h;
        route_kind   <= it.kind;
        phase        <= it.ph;
        target_row   <= it.trow;
        target_col   <= it.tcol;
        target_width <= it.tw;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        pred = route_item(it);
        expected_q.push_back(typed ? typed_res : pred);
        n_items++;
    endtask

    // registers change only with the block empty
    task automatic write_regs(input int um, input int dm, input int r0, input int r1,
                              input int r2, input int r3);
        int vals [6];
        vals = '{um, dm, r0, r1, r2, r3};
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_UP_MARGIN + i[2:0];
            cfg_wdata <= vals[i][10:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        up_mrg = um;
        down_mrg = dm;
        for (int k = 0; k < 4; k++)
            chan_row[k] = vals[k + 2];
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // result side: check each accepted item, then draw the next stall stretch
    always @(posedge clk)
    begin
        dgr_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result item row %0d col %0d", $time,
                             new_row, new_col);
                    n_fail++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("new_row", want.new_row, new_row);
                    check_field("new_col", want.new_col, new_col);
                    check_field("new_phase", want.new_phase, new_phase);
                    check_field("moved", want.moved, moved);
                    check_field("blocked", want.blocked, blocked);
                    check_field("still_active", want.still_active, still_active);
                    check_field("route_class", want.route_class, route_class);
                end
                rx_hold = calm ? 0 : $urandom_range(0, 15);
            end
            else if (rx_hold > 0)
                rx_hold--;
            out_stall <= (rx_hold != 0);
        end
    end

    // watchdog on silence across both channels
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_size();
        int u;
        u = $urandom_range(0, 99);
        if (u < 3)
            return 0;
        if (u < 6)
            return $urandom_range(MAXSZ + 1, 127);
        if (u < 10)
            return MAXSZ;
        return $urandom_range(1, 8);
    endfunction

    function automatic int any12();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    initial
    begin
        dir_row_t dir [$];
        dgr_res_t pred;
        dgr_res_t none;
        item_t    it;
        int       w, h, r, c, ph, kind, steps, u;
        int       rnd_phase;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACT_CLEAR;
        cur_row = '0;
        cur_col = '0;
        drop_width = '0;
        drop_height = '0;
        route_kind = '0;
        phase = '0;
        target_row = '0;
        target_col = '0;
        target_width = '0;
        n_fail = 0;
        n_items = 0;
        idle_cycles = 0;
        rx_hold = 0;
        calm = 1'b0;
        none = '0;
        up_mrg = 0;
        down_mrg = 0;
        foreach (chan_row[k])
            chan_row[k] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, registers at reset values
        dir.push_back('{mk(ACT_CLEAR, 5, 7, 3, 3, 1, 2, 9, 9, 3), 1,
                        mk_res(5, 7, 0, 0, 0, 0, 0)});
        // right on the class border, so the upper-left class
        dir.push_back('{mk(ACT_PLACE, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 0, 0, 0, 0, 0, CLS_UPPER_LEFT)});
        dir.push_back('{mk(ACT_PLACE, -2048, -2048, 64, 64, 3, 7, 2047, 2047, 64), 1,
                        mk_res(-2048, -2048, 0, 0, 0, 0, CLS_UPPER_RIGHT)});
        // oversized droplet far outside the grid
        dir.push_back('{mk(ACT_PLACE, 2047, 2047, 127, 127, 0, 0, -2048, -2048, 0), 1,
                        mk_res(2047, 2047, 0, 0, 0, 0, CLS_LOWER_RIGHT)});
        dir.push_back('{mk(ACT_PLACE, 360, 100, 8, 4, 0, 0, 0, 50, 127), 1,
                        mk_res(360, 100, 0, 0, 0, 0, CLS_LOWER_LEFT)});
        dir.push_back('{mk(ACT_UNUSED, -1, 1279, 127, 127, 3, 7, -1, -1, 127), 1,
                        mk_res(-1, 1279, 0, 0, 0, 0, 0)});
        // arrived and unknown phases do nothing
        dir.push_back('{mk(ACT_STEP, 30, 40, 4, 4, 2, 4, 0, 0, 4), 1,
                        mk_res(30, 40, PH_ARRIVED, 0, 0, 0, CLS_LOWER_LEFT)});
        dir.push_back('{mk(ACT_STEP, 30, 40, 4, 4, 1, 7, 0, 0, 4), 1,
                        mk_res(30, 40, PH_ARRIVED, 0, 0, 0, CLS_UPPER_LEFT)});
        // a right move past column 2047 counts as reaching the goal
        dir.push_back('{mk(ACT_STEP, 100, 2047, 4, 4, 2, 1, 0, 2047, 10), 1,
                        mk_res(100, 2047, PH_ROW_TGT, 0, 0, 1, CLS_LOWER_LEFT)});
        dir.push_back('{mk(ACT_STEP, 100, 200, 4, 4, 0, 0, 0, 0, 4), 0, none});
        dir.push_back('{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        // a move, then a neighbor inside the guard window blocks the next one
        dir.push_back('{mk(ACT_PLACE, 10, 10, 4, 4, 0, 0, 30, 10, 4), 0, none});
        dir.push_back('{mk(ACT_PLACE, 17, 10, 2, 2, 0, 0, 30, 10, 2), 0, none});
        dir.push_back('{mk(ACT_STEP, 10, 10, 4, 4, 0, 2, 30, 10, 4), 0, none});
        dir.push_back('{mk(ACT_STEP, 11, 10, 4, 4, 0, 2, 30, 10, 4), 0, none});
        dir.push_back('{mk(ACT_STEP, 11, 10, 4, 4, 0, 3, 30, 10, 4), 0, none});
        dir.push_back('{mk(ACT_STEP, 11, 10, 4, 4, 0, 2, 30, 10, 4), 0, none});
        dir.push_back('{mk(ACT_STEP, 400, 500, 3, 3, 3, 1, 0, 100, 10), 0, none});
        dir.push_back('{mk(ACT_STEP, 400, 500, 3, 3, 1, 1, 0, 600, 10), 0, none});
        dir.push_back('{mk(ACT_STEP, 400, 500, 3, 3, 2, 2, 100, 0, 10), 0, none});
        dir.push_back('{mk(ACT_STEP, 400, 500, 3, 3, 3, 3, 100, 0, 10), 0, none});
        dir.push_back('{mk(ACT_STEP, 10, 500, 3, 3, 1, 0, 100, 0, 10), 0, none});
        dir.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 2, 3, 0, 0, 0), 0, none});
        foreach (dir[i])
            send_item(dir[i].it, dir[i].typed, dir[i].res, pred);

        // a left move past column -2048 also ends the phase
        write_regs(0, 1279, 0, 0, 0, 0);
        send_item(mk(ACT_STEP, 50, -2048, 2, 2, 1, 1, 0, -2048, 2), 1,
                  mk_res(50, -2048, PH_ROW_TGT, 0, 0, 1, CLS_UPPER_LEFT), pred);

        // random part, one register setting per round
        rnd_phase = 0;
        while (n_items < ITEM_GOAL)
        begin
            case (rnd_phase % 4)
                0: write_regs(1279, 1279, 719, 719, 719, 719);
                1: write_regs(0, 0, 0, 0, 0, 0);
                default: write_regs($urandom_range(0, 40), $urandom_range(0, 40),
                                    $urandom_range(0, 719), $urandom_range(0, 719),
                                    $urandom_range(0, 719), $urandom_range(0, 719));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            rnd_phase++;
            for (int k = 0; k < 30 && n_items < ITEM_GOAL; k++)
            begin
                u = $urandom_range(0, 99);
                if (u < 3)
                    send_item(mk(ACT_CLEAR, any12(), any12(), 0, 0, 0, 0, 0, 0, 0),
                              0, none, pred);
                else if (u < 18)
                begin
                    // noise over the whole field ranges
                    it = mk(2'($urandom_range(0, 3)), any12(), any12(),
                            $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom_range(0, 3),
                            $urandom_range(0, 7), any12(), any12(), $urandom_range(0, 127));
                    if (it.act == ACT_PLACE || it.act == ACT_STEP)
                    begin
                        it.w = $urandom_range(0, 1) ? it.w : 7'($urandom_range(0, 8));
                        it.h = $urandom_range(0, 1) ? it.h : 7'($urandom_range(0, 8));
                    end
                    send_item(it, 0, none, pred);
                end
                else
                begin
                    // a placed droplet walked along its route
                    w = pick_size();
                    h = pick_size();
                    r = $urandom_range(0, ROWS - 1);
                    c = $urandom_range(0, COLS - 1);
                    it = mk(ACT_PLACE, r, c, w, h, 0, 0, $urandom_range(0, ROWS - 1),
                            $urandom_range(0, COLS - 1), pick_size());
                    if ($urandom_range(0, 4) == 0)
                        send_item(mk(ACT_PLACE, r + $urandom_range(0, 12) - 6,
                                     c + $urandom_range(0, 12) - 6, $urandom_range(1, 4),
                                     $urandom_range(1, 4), 0, 0, 0, 0, 0), 0, none, pred);
                    send_item(it, 0, none, pred);
                    kind = pred.route_class;
                    ph = $urandom_range(0, 3);
                    steps = $urandom_range(1, 30);
                    while (steps > 0 && ph < PH_ARRIVED)
                    begin
                        it.act = ACT_STEP;
                        it.kind = kind[1:0];
                        it.ph = ph[2:0];
                        send_item(it, 0, none, pred);
                        it.row = pred.new_row;
                        it.col = pred.new_col;
                        ph = pred.new_phase;
                        steps--;
                    end
                end
            end
        end

        // drain, then give the block time to show any stray result
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
